### rtl/avrg_pkg.sv
package avrg_pkg;

   localparam int SampleWidth     = 16;
   localparam int VolWidth        = 15;
   localparam int StepWidth       = 5;
   localparam int DivWidth        = 8;
   localparam int CsrIndexWidth   = 2;
   localparam int LevelLast       = 30;
   localparam int NominalStepDef  = 20;
   localparam int StepReset       = 20;
   localparam int DivSteps        = 16;
   localparam int DivCountWidth   = $clog2(DivSteps + 1);

   localparam logic [SampleWidth-1:0] SatPos = 16'h7fff;
   localparam logic [SampleWidth-1:0] SatNeg = 16'h8000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_VOLUME_STEP = 2'd0,
      CSR_RAMP_UP     = 2'd1,
      CSR_RAMP_DOWN   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [StepWidth-1:0] volume_step;
      logic [DivWidth-1:0]  ramp_up_divisor;
      logic [DivWidth-1:0]  ramp_down_divisor;
   } csr_type;

   // classified item as queued between front and back
   typedef struct packed {
      logic                   tick;
      logic                   unmute;
      logic                   neg;
      logic [SampleWidth-1:0] mag;
   } item_type;

   function automatic logic [VolWidth-1:0] level_at(input logic [StepWidth-1:0] idx);
      logic [VolWidth-1:0] lvl;
      unique case (idx)
         5'd0:  lvl = 15'd0;
         5'd1:  lvl = 15'd100;
         5'd2:  lvl = 15'd200;
         5'd3:  lvl = 15'd300;
         5'd4:  lvl = 15'd400;
         5'd5:  lvl = 15'd500;
         5'd6:  lvl = 15'd600;
         5'd7:  lvl = 15'd700;
         5'd8:  lvl = 15'd800;
         5'd9:  lvl = 15'd900;
         5'd10: lvl = 15'd1000;
         5'd11: lvl = 15'd1900;
         5'd12: lvl = 15'd2800;
         5'd13: lvl = 15'd3700;
         5'd14: lvl = 15'd4600;
         5'd15: lvl = 15'd5500;
         5'd16: lvl = 15'd6400;
         5'd17: lvl = 15'd7300;
         5'd18: lvl = 15'd8200;
         5'd19: lvl = 15'd9100;
         5'd20: lvl = 15'd10000;
         5'd21: lvl = 15'd11000;
         5'd22: lvl = 15'd12000;
         5'd23: lvl = 15'd13000;
         5'd24: lvl = 15'd14000;
         5'd25: lvl = 15'd15000;
         5'd26: lvl = 15'd16000;
         5'd27: lvl = 15'd17000;
         5'd28: lvl = 15'd18000;
         5'd29: lvl = 15'd19000;
         default: lvl = 15'd20000;   // top entry, and step 31 saturates here
      endcase
      return lvl;
   endfunction

endpackage

### rtl/avrg_front.sv
module avrg_front
   import avrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [15:0] sample_in, [16] unmute_level, zero fill
   input  logic        req_tuser,    // [0] operation
   output item_type    item,
   output logic        item_valid,
   input  logic        item_pop
);

   localparam int Depth = 2;

   item_type   slot_ff [Depth];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   incoming;
   logic       push;

   always_comb begin
      incoming.tick   = req_tuser;
      incoming.unmute = req_tdata[16];
      incoming.neg    = req_tdata[15];
      incoming.mag    = req_tdata[15] ? SampleWidth'(-req_tdata[15:0]) : req_tdata[15:0];
   end

   assign req_tready = (count_ff != 2'(Depth));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (item_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(item_pop);
      end
   end

endmodule

### rtl/avrg_back.sv
module avrg_back
   import avrg_pkg::*;
#(
   parameter int NOMINAL_STEP = NominalStepDef
) (
   input  logic        clock,
   input  logic        reset,
   input  csr_type     csr,
   input  item_type    item,
   input  logic        item_valid,
   output logic        item_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser
);

   localparam logic [StepWidth-1:0] NomIdx =
      (NOMINAL_STEP > LevelLast) ? StepWidth'(LevelLast) : StepWidth'(NOMINAL_STEP);
   localparam logic [VolWidth-1:0] NomRaw  = level_at(NomIdx);
   localparam logic [VolWidth-1:0] Nominal = (NomRaw == '0) ? VolWidth'(1) : NomRaw;
   localparam int ProdWidth = SampleWidth + VolWidth;

   // exact floor(prod / Nominal) for any prod below 2^ProdWidth:
   // multiply by ceil(2^RecipShift / Nominal) and drop RecipShift bits
   localparam int RecipWidth     = 32;
   localparam int RecipProdWidth = ProdWidth + RecipWidth;
   localparam int RecipShift     = ProdWidth + $clog2(Nominal);
   localparam logic [63:0] RecipNum =
      (64'd1 << RecipShift) + 64'(Nominal) - 64'd1;
   localparam logic [RecipWidth-1:0] Recip = RecipWidth'(RecipNum / 64'(Nominal));

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   state_type                state_ff;
   logic [VolWidth-1:0]      vol_ff;
   logic                     unmute_ff;
   logic                     tick_ff;
   logic                     up_ff;
   logic                     neg_ff;
   logic                     sat_ff;
   logic [SampleWidth-1:0]   mag_ff;
   logic [ProdWidth-1:0]     prod_ff;
   logic [SampleWidth-1:0]   num_ff;
   logic [VolWidth-1:0]      rem_ff;
   logic [VolWidth-1:0]      den_ff;
   logic [SampleWidth-1:0]   quot_ff;
   logic [DivCountWidth-1:0] cnt_ff;
   logic                     rsp_valid_ff;
   logic [47:0]              rsp_data_ff;
   logic                     rsp_user_ff;

   logic [VolWidth-1:0]       target;
   logic                      go_up;
   logic                      go_down;
   logic [VolWidth-1:0]       span;
   logic [DivWidth-1:0]       div_raw;
   logic [VolWidth-1:0]       div_eff;
   logic [VolWidth-1:0]       dist_eff;
   logic [SampleWidth-1:0]    trial;
   logic                      trial_ge;
   logic [VolWidth-1:0]       rem_next;
   logic [VolWidth-1:0]       vol_new;
   logic                      over;
   logic [SampleWidth-1:0]    scaled;
   logic                      out_free;
   logic                      rsp_load;
   logic [RecipProdWidth-1:0] recip_prod;

   // ramp decision for the item at the head of the queue
   always_comb begin
      target   = item.unmute ? level_at(csr.volume_step) : '0;
      go_up    = vol_ff < target;
      go_down  = vol_ff > target;
      span     = go_up ? (target - vol_ff) : (vol_ff - target);
      div_raw  = go_up ? csr.ramp_up_divisor : csr.ramp_down_divisor;
      div_eff  = (div_raw == '0) ? VolWidth'(1) : VolWidth'(div_raw);
      dist_eff = (span < div_eff) ? div_eff : span;
   end

   // one restoring division step; remainder stays below the divisor
   always_comb begin
      trial    = {rem_ff, num_ff[SampleWidth-1]};
      trial_ge = trial >= {1'b0, den_ff};
      rem_next = trial_ge ? VolWidth'(trial - {1'b0, den_ff}) : trial[VolWidth-1:0];
   end

   always_comb begin
      recip_prod = RecipProdWidth'(prod_ff) * RecipProdWidth'(Recip);
   end

   always_comb begin
      vol_new = vol_ff;
      if (tick_ff) begin
         vol_new = up_ff ? (vol_ff + quot_ff[VolWidth-1:0])
                         : (vol_ff - quot_ff[VolWidth-1:0]);
      end
      over   = sat_ff || (neg_ff ? (quot_ff > SatNeg) : (quot_ff > SatPos));
      scaled = over ? (neg_ff ? SatNeg : SatPos)
                    : (neg_ff ? SampleWidth'(-quot_ff) : quot_ff);
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == S_DONE) && out_free;
   assign item_pop   = (state_ff == S_IDLE) && item_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vol_ff       <= '0;
         unmute_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  unmute_ff <= item.unmute;
                  tick_ff   <= item.tick;
                  neg_ff    <= item.neg;
                  mag_ff    <= item.mag;
                  up_ff     <= go_up;
                  sat_ff    <= 1'b0;
                  num_ff    <= {1'b0, dist_eff};
                  rem_ff    <= '0;
                  den_ff    <= div_eff;
                  cnt_ff    <= '0;
                  quot_ff   <= '0;
                  if (!item.tick) begin
                     state_ff <= S_MUL;
                  end else if (go_up || go_down) begin
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= ProdWidth'(mag_ff) * ProdWidth'(vol_ff);
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               // quotient of 2^16 or more saturates anyway
               if (prod_ff >= {Nominal, 16'd0}) begin
                  sat_ff <= 1'b1;
               end else begin
                  quot_ff <= recip_prod[RecipShift +: SampleWidth];
               end
               state_ff <= S_DONE;
            end
            S_DIV: begin
               rem_ff  <= rem_next;
               num_ff  <= num_ff << 1;
               quot_ff <= {quot_ff[SampleWidth-2:0], trial_ge};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == DivCountWidth'(DivSteps - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  vol_ff       <= vol_new;
                  rsp_user_ff  <= !tick_ff;
                  rsp_data_ff  <= {(!unmute_ff && vol_new == '0), vol_new,
                                   tick_ff ? 32'd0 : {scaled, scaled}};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/audio_volume_ramp_gain.sv
// Soft-mute volume ramp with saturating gain. Each req transfer is a mono
// sample (req_tuser 0) or a ramp tick (req_tuser 1) and always updates the
// mute state from unmute_level; each yields exactly one rsp transfer. A tick
// moves the volume toward the table level at volume_step (zero when muted)
// by the remaining distance over the up or down divisor, at least one unit.
// A sample is scaled by volume / level(NOMINAL_STEP), truncated toward zero,
// saturated to 16 bits and copied to both halves of the stereo word. A tick
// runs a 16-step serial divider for the ramp (skipped when the volume is
// already at target). A sample steps through multiply, range check with a
// reciprocal multiply by the constant nominal level, and output. A two-entry
// input queue keeps req_tready high while one item is in the back end and
// another result waits on rsp. Registers are written by csr_we with no wait.
module audio_volume_ramp_gain
   import avrg_pkg::*;
#(
   parameter int NOMINAL_STEP = NominalStepDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,   // [15:0] sample_in, [16] unmute_level
   input  logic                     req_tuser,   // [0] operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,   // [31:0] stereo_word, [46:32] current_volume,
                                                 // [47] muted
   output logic                     rsp_tuser,   // [0] is_sample
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DivWidth-1:0]      csr_wdata
);

   csr_type  csr_ff;
   item_type item;
   logic     item_valid;
   logic     item_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.volume_step       <= StepWidth'(StepReset);
         csr_ff.ramp_up_divisor   <= DivWidth'(1);
         csr_ff.ramp_down_divisor <= DivWidth'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOLUME_STEP: csr_ff.volume_step       <= csr_wdata[StepWidth-1:0];
            CSR_RAMP_UP:     csr_ff.ramp_up_divisor   <= csr_wdata;
            CSR_RAMP_DOWN:   csr_ff.ramp_down_divisor <= csr_wdata;
            default: ;
         endcase
      end
   end

   avrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   avrg_back #(
      .NOMINAL_STEP (NOMINAL_STEP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/avrg_checker.sv
module avrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result transfer must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // ticks carry an all-zero stereo word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("tick result with nonzero stereo word");

   // both channels carry the same scaled sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:16] == rsp_tdata[15:0])
      else $error("stereo halves differ");

   // volume never overshoots the top table level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[46:32] <= 15'd20000)
      else $error("volume above top level");

   // muted only once the volume has reached zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47] |-> rsp_tdata[46:32] == 15'd0)
      else $error("muted flag with nonzero volume");

endmodule

bind audio_volume_ramp_gain avrg_checker u_avrg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
